>>> hw/rtl/ltb_pkg.sv
// Package for the layered tint blend core: payload structs, controller
// command/status types, state encoding and fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps

package ltb_pkg;

  localparam int unsigned NUM_CHAN  = 3;
  localparam int unsigned DIV_STEPS = 17;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;
  // floor(2^24 / 255), used for divide-by-255 with one correction step
  localparam logic [16:0] RECIP255 = 17'd65793;
  localparam logic [7:0]  DIV255   = 8'd255;
  localparam logic [7:0]  RND255   = 8'd127;

  typedef struct packed {
    logic [7:0] layer_red;
    logic [7:0] layer_green;
    logic [7:0] layer_blue;
    logic [7:0] layer_strength;
    logic       last_layer;
  } ltb_in_t;

  typedef struct packed {
    logic [16:0] out_red;
    logic [16:0] out_green;
    logic [16:0] out_blue;
    logic [16:0] out_alpha;
  } ltb_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALPHA,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_MIX,
    ST_WAIT_OUT,
    ST_OUT_MUL,
    ST_OUT_FIX,
    ST_EMIT
  } ltb_state_e;

  typedef struct packed {
    logic       load;
    logic       alpha;
    logic       div_init;
    logic       div_step;
    logic       mix;
    logic       out_mul;
    logic       out_fix;
    logic       emit;
    logic [1:0] chan;
  } ltb_cmd_t;

  typedef struct packed {
    logic skip;
    logic in_last;
    logic last;
  } ltb_stat_t;

endpackage

>>> hw/rtl/ltb_ctrl.sv
// Sequencer for the tint blend core: walks alpha update, divider, channel
// mixes and output scaling. Depends on ltb_pkg.
`timescale 1ns / 1ps

module ltb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ltb_pkg::ltb_stat_t st_i,
  output ltb_pkg::ltb_cmd_t  cmd_o
);
  import ltb_pkg::*;

  ltb_state_e  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (st_i.skip) begin
            state_d = st_i.in_last ? ST_WAIT_OUT : ST_IDLE;
          end else begin
            state_d = ST_ALPHA;
          end
        end
      end
      ST_ALPHA: begin
        state_d = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        state_d = ST_DIV_STEP;
        cnt_d   = '0;
      end
      ST_DIV_STEP: begin
        if (cnt_q == 5'(DIV_STEPS - 1)) begin
          state_d = ST_MIX;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_MIX: begin
        if (cnt_q == 5'(NUM_CHAN - 1)) begin
          state_d = st_i.last ? ST_WAIT_OUT : ST_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_WAIT_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_OUT_MUL;
          cnt_d   = '0;
        end
      end
      ST_OUT_MUL: begin
        state_d = ST_OUT_FIX;
      end
      ST_OUT_FIX: begin
        if (cnt_q == 5'(NUM_CHAN - 1)) begin
          state_d = ST_EMIT;
          cnt_d   = '0;
        end else begin
          state_d = ST_OUT_MUL;
          cnt_d   = cnt_q + 5'd1;
        end
      end
      ST_EMIT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.chan     = cnt_q[1:0];
    in_ready_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_ALPHA:    cmd_o.alpha    = 1'b1;
      ST_DIV_INIT: cmd_o.div_init = 1'b1;
      ST_DIV_STEP: cmd_o.div_step = 1'b1;
      ST_MIX:      cmd_o.mix      = 1'b1;
      ST_OUT_MUL:  cmd_o.out_mul  = 1'b1;
      ST_OUT_FIX:  cmd_o.out_fix  = 1'b1;
      ST_EMIT:     cmd_o.emit     = 1'b1;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == ST_EMIT) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/ltb_datapath.sv
// Datapath for the tint blend core: accumulators, alpha update, restoring
// divider, shared channel mixer and divide-by-255 output scaler.
// Depends on ltb_pkg.
`timescale 1ns / 1ps

module ltb_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ltb_pkg::ltb_in_t  in_data_i,
  input  ltb_pkg::ltb_cmd_t cmd_i,
  output ltb_pkg::ltb_stat_t st_o,
  output ltb_pkg::ltb_out_t out_data_o
);
  import ltb_pkg::*;

  // accumulators
  logic [23:0] acc_q [NUM_CHAN];
  logic [16:0] acc_alpha_q;

  // latched layer
  logic [7:0]  col_q [NUM_CHAN];
  logic [16:0] w_q;
  logic        last_q;

  // divider
  logic [16:0] rem_q;
  logic [16:0] nlo_q;
  logic [16:0] quo_q;
  logic        ovf_q;

  // output scaling
  logic [41:0] ro_prod_q;
  logic [16:0] res_q [NUM_CHAN];
  logic [16:0] res_alpha_q;

  logic [16:0] w_in;
  logic [16:0] a_cl;
  logic [33:0] grow_prod;
  logic [17:0] a_sum;
  logic [32:0] div_n;
  logic [17:0] div_t;
  logic        div_ge;
  logic [16:0] v_w;
  logic [23:0] c_sel;
  logic signed [24:0] mix_d;
  logic signed [42:0] mix_prod;
  logic signed [42:0] mix_sum;
  logic [24:0] ro_x;
  logic [17:0] ro_q0;
  logic [25:0] ro_r;
  logic [17:0] ro_q;

  // w = round(s * 65536 / 255) = s*257 + (s >= 128)
  assign w_in = {1'b0, in_data_i.layer_strength, 8'h0}
              + {9'h0, in_data_i.layer_strength}
              + {16'h0, in_data_i.layer_strength[7]};

  assign a_cl      = (acc_alpha_q > ONE_Q16) ? ONE_Q16 : acc_alpha_q;
  assign grow_prod = {17'h0, w_q} * {17'h0, ONE_Q16 - a_cl};
  assign a_sum     = {1'b0, a_cl} + 18'((grow_prod + {17'h0, HALF_Q16}) >> 16);

  assign div_n  = {w_q, 16'h0} + {17'h0, acc_alpha_q[16:1]};
  assign div_t  = {rem_q, nlo_q[16]};
  assign div_ge = div_t >= {1'b0, acc_alpha_q};

  assign v_w = (ovf_q || quo_q > ONE_Q16) ? ONE_Q16 : quo_q;

  assign c_sel    = acc_q[cmd_i.chan];
  assign mix_d    = $signed({1'b0, col_q[cmd_i.chan], 16'h0}) - $signed({1'b0, c_sel});
  assign mix_prod = 43'(mix_d) * 43'($signed({1'b0, v_w}));
  assign mix_sum  = mix_prod + 43'sd32768;

  assign ro_x  = {1'b0, c_sel} + {17'h0, RND255};
  assign ro_q0 = ro_prod_q[41:24];
  assign ro_r  = {1'b0, ro_x} - ({ro_q0, 8'h0} - {8'h0, ro_q0});
  assign ro_q  = (ro_r >= {18'h0, DIV255}) ? ro_q0 + 18'd1 : ro_q0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        acc_q[i] <= '0;
      end
      acc_alpha_q <= '0;
    end else begin
      if (cmd_i.alpha) begin
        acc_alpha_q <= (a_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : a_sum[16:0];
      end
      if (cmd_i.mix) begin
        acc_q[cmd_i.chan] <= c_sel + mix_sum[39:16];
      end
      if (cmd_i.emit) begin
        for (int i = 0; i < NUM_CHAN; i++) begin
          acc_q[i] <= '0;
        end
        acc_alpha_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q[0] <= in_data_i.layer_red;
      col_q[1] <= in_data_i.layer_green;
      col_q[2] <= in_data_i.layer_blue;
      w_q      <= w_in;
      last_q   <= in_data_i.last_layer;
    end
    if (cmd_i.div_init) begin
      ovf_q <= {1'b0, div_n[32:17]} >= acc_alpha_q;
      rem_q <= {1'b0, div_n[32:17]};
      nlo_q <= div_n[16:0];
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= div_ge ? 17'(div_t - {1'b0, acc_alpha_q}) : div_t[16:0];
      quo_q <= {quo_q[15:0], div_ge};
      nlo_q <= {nlo_q[15:0], 1'b0};
    end
    if (cmd_i.out_mul) begin
      ro_prod_q <= {17'h0, ro_x} * {25'h0, RECIP255};
    end
    if (cmd_i.out_fix) begin
      res_q[cmd_i.chan] <= (ro_q > {1'b0, ONE_Q16}) ? ONE_Q16 : ro_q[16:0];
    end
    if (cmd_i.emit) begin
      res_alpha_q <= a_cl;
    end
  end

  assign st_o.skip    = (in_data_i.layer_strength == 8'h0);
  assign st_o.in_last = in_data_i.last_layer;
  assign st_o.last    = last_q;

  assign out_data_o.out_red   = res_q[0];
  assign out_data_o.out_green = res_q[1];
  assign out_data_o.out_blue  = res_q[2];
  assign out_data_o.out_alpha = res_alpha_q;

endmodule

>>> hw/rtl/layered_tint_blend_core.sv
// Channel | Signals                              | Transfer when
// input   | in_valid_i, in_ready_o, in_data_i    | in_valid_i && in_ready_o
// output  | out_valid_o, out_ready_i, out_data_o | out_valid_o && out_ready_i
//
// A layer with nonzero strength is accepted, then passes alpha update, divider
// setup, 17 restoring-divider steps, then 3 channel mixes on one multiplier.
// A zero-strength layer is only accepted. A last layer adds output scaling by
// 1/255, a multiply and a fix step per channel, plus wait and emit. Reset clears
// accumulators and control. A full output register stalls only a last layer,
// before its scaling starts.
//
// Top level of the layered tint blend core. Depends on ltb_pkg, ltb_ctrl
// and ltb_datapath.
`timescale 1ns / 1ps

module layered_tint_blend_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ltb_pkg::ltb_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ltb_pkg::ltb_out_t out_data_o
);
  import ltb_pkg::*;

  ltb_cmd_t  cmd;
  ltb_stat_t st;

  ltb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  ltb_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .st_o       (st),
    .out_data_o (out_data_o)
  );

endmodule

>>> hw/rtl/ltb_checker.sv
// Port-level checks for the layered tint blend core, bound to the top level.
// Depends on ltb_pkg.
`timescale 1ns / 1ps

module ltb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input ltb_pkg::ltb_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ltb_pkg::ltb_out_t out_data_o
);
  import ltb_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_red <= ONE_Q16 && out_data_o.out_green <= ONE_Q16
                 && out_data_o.out_blue <= ONE_Q16 && out_data_o.out_alpha <= ONE_Q16)
    else $error("output field above one");

  a_busy_after_layer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.layer_strength != 8'h0 |=> !in_ready_o)
    else $error("input taken while a layer is in progress");

endmodule

bind layered_tint_blend_core ltb_checker u_ltb_checker (.*);
